// ===== hdl/cmap_pkg.sv =====
// Package for the contact map block: field widths, coordinate type, sequencer states.
// No dependencies. Compiled first.
package cmap_pkg;

  localparam int COORD_W    = 20;
  localparam int CUTOFF_W   = 16;
  localparam int ROW_W      = 6;
  localparam int ROW_BITS_W = 64;
  localparam int MIN_SEP    = 4;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int CUT2_W     = 2 * CUTOFF_W;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'd2048;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PIVOT,
    ST_SWEEP,
    ST_DRAIN,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/cmap_in_if.sv =====
// Input channel of the contact map block: one coordinate per transfer.
// Depends on cmap_pkg.
interface cmap_in_if;
  import cmap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic                      last_point;

  modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface

// ===== hdl/cmap_out_if.sv =====
// Result channel of the contact map block: one map row per transfer.
// Depends on cmap_pkg.
interface cmap_out_if;
  import cmap_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ROW_W-1:0]      row_index;
  logic [ROW_BITS_W-1:0] row_bits;
  logic                  last_row;
  logic                  overflow;

  modport source (output valid, row_index, row_bits, last_row, overflow, input ready);
  modport sink   (input valid, row_index, row_bits, last_row, overflow, output ready);
endinterface

// ===== hdl/contact_map_from_coordinates.sv =====
// Top level of the residue contact map block.
// Depends on cmap_pkg, cmap_in_if, cmap_out_if, cmap_ram and cmap_dist.
//
// Usage:
//   in_ch carries one 3D point per transfer (20-bit signed, 8 fractional
//   bits). Points are stored one per cycle; a point that arrives with the
//   store full is dropped and the overflow flag of the set is raised.
//   A transfer with last_point set ends the set and starts map output.
//   out_ch then carries one row per transfer, rows in rising order, the
//   final row marked by last_row. in_ch is not ready while rows go out.
//   cfg_we/cfg_wdata load the cutoff (reset 8.0 A); write it only between
//   sets.
// Sequencing:
//   Loading: one point per cycle. Output: each row sweeps all n stored points
//   through the single RAM read port, then the distance pipeline drains
//   and the row is offered. A stalled row holds in the output register and
//   the next row starts after its transfer.
// Reset (synchronous, rst_n low) empties the point count, clears overflow
// and restores the cutoff; stored coordinates are not cleared.
module contact_map_from_coordinates #(
  parameter int MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  cmap_in_if.sink                       in_ch,
  cmap_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [cmap_pkg::CUTOFF_W-1:0] cfg_wdata
);
  import cmap_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [AW-1:0]         row_r, row_nxt;
  logic [AW-1:0]         col_r, col_nxt;
  logic [MAX_POINTS-1:0] bits_r, bits_nxt;
  logic [CUTOFF_W-1:0]   cutoff_r;
  logic [CUT2_W-1:0]     cut2_r;
  coord_t                pivot_r;
  logic                  piv_ld_r;
  logic                  rd_v_r;
  logic [AW-1:0]         rd_col_r;

  logic          in_xfer, out_xfer, has_room, col_last, row_last;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  coord_t        ram_wdata, ram_rdata;
  logic          dist_busy, hit_valid, hit;
  logic [AW-1:0] hit_col;

  assign in_xfer  = in_ch.valid & in_ch.ready;
  assign out_xfer = out_ch.valid & out_ch.ready;
  assign has_room = (count_r < CW'(MAX_POINTS));
  assign col_last = (CW'(col_r) + CW'(1) == n_r);
  assign row_last = (CW'(row_r) + CW'(1) == n_r);

  assign ram_we    = in_xfer & has_room;
  assign ram_wdata = '{x: in_ch.x_coord, y: in_ch.y_coord, z: in_ch.z_coord};

  cmap_ram #(
    .WIDTH($bits(coord_t)),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cmap_dist #(
    .AW(AW)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_v_r),
    .in_col    (rd_col_r),
    .row       (row_r),
    .pivot     (pivot_r),
    .point     (ram_rdata),
    .cut2      (cut2_r),
    .busy      (dist_busy),
    .hit_valid (hit_valid),
    .hit_col   (hit_col),
    .hit       (hit)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_ch.last_point) begin
          state_nxt = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (col_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !dist_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          state_nxt = row_last ? ST_LOAD : ST_PIVOT;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ch.ready  = (state_r == ST_LOAD);
    out_ch.valid = (state_r == ST_OUT);
    ram_raddr    = (state_r == ST_PIVOT) ? row_r : col_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    ovf_nxt      = ovf_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    bits_nxt     = bits_r;
    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (has_room) begin
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          n_nxt   = has_room ? count_r + CW'(1) : count_r;
          row_nxt = '0;
        end
      end
      ST_PIVOT: begin
        col_nxt  = '0;
        bits_nxt = '0;
      end
      ST_SWEEP: begin
        col_nxt = col_r + AW'(1);
      end
      ST_OUT: begin
        if (out_xfer) begin
          if (row_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            row_nxt = row_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
    if (hit_valid && hit) begin
      bits_nxt[hit_col] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      cutoff_r <= CUTOFF_RESET;
      piv_ld_r <= 1'b0;
      rd_v_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      piv_ld_r <= (state_r == ST_PIVOT);
      rd_v_r   <= (state_r == ST_SWEEP);
      if (cfg_we) begin
        cutoff_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    bits_r   <= bits_nxt;
    rd_col_r <= col_r;
    if (piv_ld_r) begin
      pivot_r <= ram_rdata;
    end
    if (in_xfer && in_ch.last_point) begin
      cut2_r <= CUT2_W'(cutoff_r) * CUT2_W'(cutoff_r);
    end
  end

  assign out_ch.row_index = ROW_W'(row_r);
  assign out_ch.row_bits  = ROW_BITS_W'(bits_r);
  assign out_ch.last_row  = row_last;
  assign out_ch.overflow  = ovf_r;

endmodule

// ===== hdl/cmap_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmap_ram #(
  parameter int WIDTH = 60,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/cmap_dist.sv =====
// Three-stage squared-distance pipeline with the contact decision at its end.
// Depends on cmap_pkg.
module cmap_dist #(
  parameter int AW = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [AW-1:0]                in_col,
  input  logic [AW-1:0]                row,
  input  cmap_pkg::coord_t             pivot,
  input  cmap_pkg::coord_t             point,
  input  logic [cmap_pkg::CUT2_W-1:0]  cut2,
  output logic                         busy,
  output logic                         hit_valid,
  output logic [AW-1:0]                hit_col,
  output logic                         hit
);
  import cmap_pkg::*;

  logic              v_b_r, v_c_r, v_d_r;
  logic [AW-1:0]     col_b_r, col_c_r, col_d_r;
  logic              eq_b_r, eq_c_r, eq_d_r;
  logic              sep_b_r, sep_c_r, sep_d_r;
  logic [DIFF_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [DIST_W-1:0] dist2_r;

  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [AW-1:0]            sep;

  always_comb begin
    dx  = DIFF_W'(pivot.x) - DIFF_W'(point.x);
    dy  = DIFF_W'(pivot.y) - DIFF_W'(point.y);
    dz  = DIFF_W'(pivot.z) - DIFF_W'(point.z);
    sep = (row > in_col) ? (row - in_col) : (in_col - row);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else begin
      v_b_r <= in_valid;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    col_b_r <= in_col;
    eq_b_r  <= (row == in_col);
    sep_b_r <= ({1'b0, sep} >= (AW + 1)'(MIN_SEP));
    ax_r    <= dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ay_r    <= dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    az_r    <= dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);

    col_c_r <= col_b_r;
    eq_c_r  <= eq_b_r;
    sep_c_r <= sep_b_r;
    sx_r    <= SQ_W'(ax_r) * SQ_W'(ax_r);
    sy_r    <= SQ_W'(ay_r) * SQ_W'(ay_r);
    sz_r    <= SQ_W'(az_r) * SQ_W'(az_r);

    col_d_r <= col_c_r;
    eq_d_r  <= eq_c_r;
    sep_d_r <= sep_c_r;
    dist2_r <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  end

  assign busy      = v_b_r | v_c_r | v_d_r;
  assign hit_valid = v_d_r;
  assign hit_col   = col_d_r;
  assign hit       = eq_d_r | (sep_d_r & (dist2_r < DIST_W'(cut2)));

endmodule
